FILE: rtl/pad_pkg.sv
// shared types, widths and the multiply step table of the polyline angle downsampler
`default_nettype none

package pad_pkg;

    localparam int COORD_BITS = 32;
    localparam int DIFF_W     = COORD_BITS + 1;
    localparam int CHUNK_W    = DIFF_W;
    localparam int SQ_W       = 2 * CHUNK_W;
    localparam int DOT_W      = SQ_W + 2;
    localparam int P_W        = 2 * SQ_W;
    localparam int TH_W       = 16;
    localparam int TH2_W      = 2 * TH_W - 1;
    localparam int TH_SHIFT   = 2 * (TH_W - 1);
    localparam int MUL_W      = (CHUNK_W > TH2_W) ? CHUNK_W : TH2_W;
    localparam int PROD_W     = 2 * MUL_W;
    localparam int ACC_W      = P_W + TH_SHIFT;
    localparam int N_STEPS    = 22;
    localparam int STEP_W     = $clog2(N_STEPS);
    localparam int SHIFT_W    = 2;
    localparam int N_OPND     = 18;

    localparam logic signed [TH_W-1:0] COS_TH_RESET = 16'sd32756;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] pos_x;
        logic signed [COORD_BITS-1:0] pos_y;
        logic signed [COORD_BITS-1:0] pos_z;
        logic                         path_end;
    } pad_in_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] kept_x;
        logic signed [COORD_BITS-1:0] kept_y;
        logic signed [COORD_BITS-1:0] kept_z;
        logic                         run_last;
    } pad_out_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ROUTE,
        S_MUL,
        S_DRAIN,
        S_DECIDE,
        S_EMIT_HELD,
        S_EMIT_CUR
    } pad_state_t;

    typedef enum logic [1:0] {
        SEEN_NONE,
        SEEN_ONE,
        SEEN_MANY
    } pad_seen_t;

    typedef enum logic [4:0] {
        OPD_TH,
        OPD_D1X,
        OPD_D1Y,
        OPD_D1Z,
        OPD_D2X,
        OPD_D2Y,
        OPD_D2Z,
        OPD_L1LO,
        OPD_L1HI,
        OPD_L2LO,
        OPD_L2HI,
        OPD_DOTLO,
        OPD_DOTHI,
        OPD_P0,
        OPD_P1,
        OPD_P2,
        OPD_P3,
        OPD_TH2
    } pad_opnd_t;

    typedef enum logic [2:0] {
        DST_TH2,
        DST_L1,
        DST_L2,
        DST_DOT,
        DST_P,
        DST_LHS,
        DST_RHS
    } pad_dst_t;

    typedef enum logic {
        OUT_HELD,
        OUT_CUR
    } pad_sel_t;

    typedef struct packed {
        pad_opnd_t          a;
        pad_opnd_t          b;
        pad_dst_t           dst;
        logic [SHIFT_W-1:0] shift;
    } pad_mop_t;

    typedef struct packed {
        logic              in_load;
        logic              diff_load;
        logic              mul_go;
        logic [STEP_W-1:0] mul_step;
        logic              hist_shift;
        logic              out_load;
        pad_sel_t          out_sel;
        logic              out_last;
    } pad_cmd_t;

    typedef struct packed {
        logic keep;
        logic cur_end;
        logic out_busy;
    } pad_stat_t;

    // one shared multiply per step; shift counts in chunks of CHUNK_W bits
    function automatic pad_mop_t pad_step_op(input logic [STEP_W-1:0] step);
        pad_mop_t op;
        op.a     = OPD_TH;
        op.b     = OPD_TH;
        op.dst   = DST_TH2;
        op.shift = '0;
        case (int'(step))
            1: begin op.a = OPD_D1X; op.b = OPD_D1X; op.dst = DST_L1; end
            2: begin op.a = OPD_D1Y; op.b = OPD_D1Y; op.dst = DST_L1; end
            3: begin op.a = OPD_D1Z; op.b = OPD_D1Z; op.dst = DST_L1; end
            4: begin op.a = OPD_D2X; op.b = OPD_D2X; op.dst = DST_L2; end
            5: begin op.a = OPD_D2Y; op.b = OPD_D2Y; op.dst = DST_L2; end
            6: begin op.a = OPD_D2Z; op.b = OPD_D2Z; op.dst = DST_L2; end
            7: begin op.a = OPD_D1X; op.b = OPD_D2X; op.dst = DST_DOT; end
            8: begin op.a = OPD_D1Y; op.b = OPD_D2Y; op.dst = DST_DOT; end
            9: begin op.a = OPD_D1Z; op.b = OPD_D2Z; op.dst = DST_DOT; end
            10: begin op.a = OPD_L1LO; op.b = OPD_L2LO; op.dst = DST_P; op.shift = 2'd0; end
            11: begin op.a = OPD_L1LO; op.b = OPD_L2HI; op.dst = DST_P; op.shift = 2'd1; end
            12: begin op.a = OPD_L1HI; op.b = OPD_L2LO; op.dst = DST_P; op.shift = 2'd1; end
            13: begin op.a = OPD_L1HI; op.b = OPD_L2HI; op.dst = DST_P; op.shift = 2'd2; end
            14: begin op.a = OPD_DOTLO; op.b = OPD_DOTLO; op.dst = DST_LHS; op.shift = 2'd0; end
            15: begin op.a = OPD_DOTLO; op.b = OPD_DOTHI; op.dst = DST_LHS; op.shift = 2'd1; end
            16: begin op.a = OPD_DOTHI; op.b = OPD_DOTLO; op.dst = DST_LHS; op.shift = 2'd1; end
            17: begin op.a = OPD_DOTHI; op.b = OPD_DOTHI; op.dst = DST_LHS; op.shift = 2'd2; end
            18: begin op.a = OPD_TH2; op.b = OPD_P0; op.dst = DST_RHS; op.shift = 2'd0; end
            19: begin op.a = OPD_TH2; op.b = OPD_P1; op.dst = DST_RHS; op.shift = 2'd1; end
            20: begin op.a = OPD_TH2; op.b = OPD_P2; op.dst = DST_RHS; op.shift = 2'd2; end
            21: begin op.a = OPD_TH2; op.b = OPD_P3; op.dst = DST_RHS; op.shift = 2'd3; end
            default: begin
                op.a   = OPD_TH;
                op.b   = OPD_TH;
                op.dst = DST_TH2;
            end
        endcase
        return op;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/pad_ctrl.sv
// controller state machine: path position tracking and multiply sequencing
`default_nettype none

module pad_ctrl
    import pad_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire pad_stat_t stat,
    output pad_cmd_t       cmd
);

    pad_state_t        state_reg, state_next;
    pad_seen_t         seen_reg, seen_next;
    logic [STEP_W-1:0] step_reg, step_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            seen_reg  <= SEEN_NONE;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            seen_reg  <= seen_next;
            step_reg  <= step_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        seen_next  = seen_reg;
        step_next  = step_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) state_next = S_ROUTE;
            end
            S_ROUTE: begin
                case (seen_reg)
                    SEEN_NONE: state_next = S_EMIT_CUR;
                    SEEN_ONE: begin
                        if (stat.cur_end) begin
                            state_next = S_EMIT_CUR;
                        end else begin
                            seen_next  = SEEN_MANY;
                            state_next = S_IDLE;
                        end
                    end
                    default: state_next = S_MUL;
                endcase
            end
            S_MUL: begin
                if (step_reg == STEP_W'(N_STEPS - 1)) begin
                    step_next  = '0;
                    state_next = S_DRAIN;
                end else begin
                    step_next = step_reg + 1'b1;
                end
            end
            S_DRAIN: state_next = S_DECIDE;
            S_DECIDE: begin
                if (stat.keep)         state_next = S_EMIT_HELD;
                else if (stat.cur_end) state_next = S_EMIT_CUR;
                else                   state_next = S_IDLE;
            end
            S_EMIT_HELD: begin
                if (!stat.out_busy) state_next = stat.cur_end ? S_EMIT_CUR : S_IDLE;
            end
            S_EMIT_CUR: begin
                if (!stat.out_busy) begin
                    seen_next  = stat.cur_end ? SEEN_NONE : SEEN_ONE;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready     = 1'b1;
                cmd.in_load = s_valid;
            end
            S_ROUTE: begin
                if (seen_reg == SEEN_ONE && !stat.cur_end) cmd.hist_shift = 1'b1;
                if (seen_reg == SEEN_MANY)                 cmd.diff_load  = 1'b1;
            end
            S_MUL: begin
                cmd.mul_go   = 1'b1;
                cmd.mul_step = step_reg;
            end
            S_DECIDE: begin
                // dropped middle point, path goes on
                if (!stat.keep && !stat.cur_end) cmd.hist_shift = 1'b1;
            end
            S_EMIT_HELD: begin
                if (!stat.out_busy) begin
                    cmd.out_load   = 1'b1;
                    cmd.out_sel    = OUT_HELD;
                    cmd.out_last   = 1'b0;
                    cmd.hist_shift = !stat.cur_end;
                end
            end
            S_EMIT_CUR: begin
                if (!stat.out_busy) begin
                    cmd.out_load   = 1'b1;
                    cmd.out_sel    = OUT_CUR;
                    cmd.out_last   = stat.cur_end;
                    cmd.hist_shift = !stat.cur_end;
                end
            end
            default: begin
                cmd     = '0;
                s_ready = 1'b0;
            end
        endcase
    end

    a_step_only_in_mul: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_MUL) |-> (step_reg == '0))
        else $error("step counter left non-zero outside the multiply sequence");

    a_load_not_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> !stat.out_busy)
        else $error("output register loaded while its transfer is still pending");

    a_decide_after_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DECIDE) |-> ($past(state_reg) == S_DRAIN))
        else $error("decision taken before the product pipeline drained");

    a_held_never_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.out_load && cmd.out_sel == OUT_HELD) |-> !cmd.out_last)
        else $error("middle point emitted with the last flag");

endmodule

`default_nettype wire

FILE: rtl/pad_dpath.sv
// datapath: point history, shared multiplier, wide accumulators, angle test, output register
`default_nettype none

module pad_dpath
    import pad_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire pad_in_t                s_data,
    input  wire logic signed [TH_W-1:0] cos_threshold,
    input  wire pad_cmd_t               cmd,
    output pad_stat_t                   stat,
    input  wire logic                   m_ready,
    output logic                        m_valid,
    output pad_out_t                    m_data
);

    localparam int MSB = COORD_BITS - 1;

    logic [2:0][COORD_BITS-1:0] cur_reg, hd_reg, pr_reg;
    logic                       cur_end_reg;

    logic [2:0][DIFF_W-1:0] d1_w, d2_w;
    logic [2:0][DIFF_W-1:0] d1_reg, d2_reg;
    logic [2:0][DIFF_W-1:0] d1_mag, d2_mag;
    logic                   z1_reg, z2_reg;

    logic [TH2_W-1:0] th2_reg;
    logic [SQ_W-1:0]  l1_reg, l2_reg;
    logic [DOT_W-1:0] dot_reg, dot_mag;
    logic [P_W-1:0]   p_reg, lhs_reg;
    logic [ACC_W-1:0] rhs_reg;

    logic [TH_W-1:0]   th_mag;
    logic [MUL_W-1:0]  opnd_mag [N_OPND];
    logic [N_OPND-1:0] opnd_neg;
    pad_mop_t          mop;
    logic [MUL_W-1:0]  a_mag, b_mag;
    logic [PROD_W-1:0] prod_next, prod_reg;

    logic               acc_en_reg;
    pad_dst_t           acc_dst_reg;
    logic [SHIFT_W-1:0] acc_shift_reg;
    logic               acc_neg_reg;
    logic [ACC_W-1:0]   acc_base, acc_addend, acc_sum;

    logic [ACC_W-1:0] lhs_sh;
    logic             lhs_lt, lhs_gt, dot_neg, th_neg;

    logic       m_valid_reg;
    pad_out_t   m_data_reg;
    logic [2:0][COORD_BITS-1:0] out_pt;

    // segment differences, exact at one bit wider than a coordinate
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            d1_w[k] = {hd_reg[k][MSB], hd_reg[k]} - {pr_reg[k][MSB], pr_reg[k]};
            d2_w[k] = {cur_reg[k][MSB], cur_reg[k]} - {hd_reg[k][MSB], hd_reg[k]};
            d1_mag[k] = d1_reg[k][DIFF_W-1] ? -d1_reg[k] : d1_reg[k];
            d2_mag[k] = d2_reg[k][DIFF_W-1] ? -d2_reg[k] : d2_reg[k];
        end
    end

    assign th_mag  = cos_threshold[TH_W-1] ? -cos_threshold : cos_threshold;
    assign dot_mag = dot_reg[DOT_W-1] ? -dot_reg : dot_reg;

    always_comb begin
        for (int i = 0; i < N_OPND; i++) opnd_mag[i] = '0;
        opnd_neg = '0;
        opnd_mag[OPD_TH]    = MUL_W'(th_mag);
        opnd_mag[OPD_D1X]   = MUL_W'(d1_mag[0]);
        opnd_mag[OPD_D1Y]   = MUL_W'(d1_mag[1]);
        opnd_mag[OPD_D1Z]   = MUL_W'(d1_mag[2]);
        opnd_mag[OPD_D2X]   = MUL_W'(d2_mag[0]);
        opnd_mag[OPD_D2Y]   = MUL_W'(d2_mag[1]);
        opnd_mag[OPD_D2Z]   = MUL_W'(d2_mag[2]);
        opnd_mag[OPD_L1LO]  = MUL_W'(l1_reg[CHUNK_W-1:0]);
        opnd_mag[OPD_L1HI]  = MUL_W'(l1_reg[SQ_W-1:CHUNK_W]);
        opnd_mag[OPD_L2LO]  = MUL_W'(l2_reg[CHUNK_W-1:0]);
        opnd_mag[OPD_L2HI]  = MUL_W'(l2_reg[SQ_W-1:CHUNK_W]);
        opnd_mag[OPD_DOTLO] = MUL_W'(dot_mag[CHUNK_W-1:0]);
        opnd_mag[OPD_DOTHI] = MUL_W'(dot_mag[SQ_W-1:CHUNK_W]);
        opnd_mag[OPD_P0]    = MUL_W'(p_reg[0*CHUNK_W +: CHUNK_W]);
        opnd_mag[OPD_P1]    = MUL_W'(p_reg[1*CHUNK_W +: CHUNK_W]);
        opnd_mag[OPD_P2]    = MUL_W'(p_reg[2*CHUNK_W +: CHUNK_W]);
        opnd_mag[OPD_P3]    = MUL_W'(p_reg[3*CHUNK_W +: CHUNK_W]);
        opnd_mag[OPD_TH2]   = MUL_W'(th2_reg);
        opnd_neg[OPD_D1X]   = d1_reg[0][DIFF_W-1];
        opnd_neg[OPD_D1Y]   = d1_reg[1][DIFF_W-1];
        opnd_neg[OPD_D1Z]   = d1_reg[2][DIFF_W-1];
        opnd_neg[OPD_D2X]   = d2_reg[0][DIFF_W-1];
        opnd_neg[OPD_D2Y]   = d2_reg[1][DIFF_W-1];
        opnd_neg[OPD_D2Z]   = d2_reg[2][DIFF_W-1];
    end

    assign mop       = pad_step_op(cmd.mul_step);
    assign a_mag     = opnd_mag[mop.a];
    assign b_mag     = opnd_mag[mop.b];
    assign prod_next = a_mag * b_mag;

    always_comb begin
        acc_base = '0;
        case (acc_dst_reg)
            DST_L1:  acc_base = ACC_W'(l1_reg);
            DST_L2:  acc_base = ACC_W'(l2_reg);
            DST_DOT: acc_base = ACC_W'(dot_reg);
            DST_P:   acc_base = ACC_W'(p_reg);
            DST_LHS: acc_base = ACC_W'(lhs_reg);
            DST_RHS: acc_base = rhs_reg;
            default: acc_base = '0;
        endcase
        case (acc_shift_reg)
            2'd1:    acc_addend = ACC_W'(prod_reg) << CHUNK_W;
            2'd2:    acc_addend = ACC_W'(prod_reg) << (2 * CHUNK_W);
            2'd3:    acc_addend = ACC_W'(prod_reg) << (3 * CHUNK_W);
            default: acc_addend = ACC_W'(prod_reg);
        endcase
        acc_sum = acc_neg_reg ? acc_base - acc_addend : acc_base + acc_addend;
    end

    // product register and its destination tag form the pipeline stage ahead of the accumulators
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_en_reg <= 1'b0;
        end else begin
            acc_en_reg <= cmd.mul_go;
        end
        prod_reg      <= prod_next;
        acc_dst_reg   <= mop.dst;
        acc_shift_reg <= mop.shift;
        acc_neg_reg   <= opnd_neg[mop.a] ^ opnd_neg[mop.b];
    end

    always_ff @(posedge aclk) begin
        if (cmd.diff_load) begin
            d1_reg  <= d1_w;
            d2_reg  <= d2_w;
            z1_reg  <= (d1_w == '0);
            z2_reg  <= (d2_w == '0);
            l1_reg  <= '0;
            l2_reg  <= '0;
            dot_reg <= '0;
            p_reg   <= '0;
            lhs_reg <= '0;
            rhs_reg <= '0;
        end else if (acc_en_reg) begin
            case (acc_dst_reg)
                DST_TH2: th2_reg <= acc_sum[TH2_W-1:0];
                DST_L1:  l1_reg  <= acc_sum[SQ_W-1:0];
                DST_L2:  l2_reg  <= acc_sum[SQ_W-1:0];
                DST_DOT: dot_reg <= acc_sum[DOT_W-1:0];
                DST_P:   p_reg   <= acc_sum[P_W-1:0];
                DST_LHS: lhs_reg <= acc_sum[P_W-1:0];
                DST_RHS: rhs_reg <= acc_sum;
                default: ;
            endcase
        end
    end

    // dot^2 * 2^30 against cos^2 * |d1|^2 * |d2|^2, signs first
    assign lhs_sh  = {lhs_reg, {TH_SHIFT{1'b0}}};
    assign lhs_lt  = lhs_sh < rhs_reg;
    assign lhs_gt  = lhs_sh > rhs_reg;
    assign dot_neg = dot_reg[DOT_W-1];
    assign th_neg  = cos_threshold[TH_W-1];

    assign stat.keep     = z1_reg | z2_reg | (th_neg ? (dot_neg & lhs_gt) : (dot_neg | lhs_lt));
    assign stat.cur_end  = cur_end_reg;
    assign stat.out_busy = m_valid_reg & ~m_ready;

    always_ff @(posedge aclk) begin
        if (cmd.in_load) begin
            cur_reg     <= {s_data.pos_z, s_data.pos_y, s_data.pos_x};
            cur_end_reg <= s_data.path_end;
        end
        if (cmd.hist_shift) begin
            pr_reg <= hd_reg;
            hd_reg <= cur_reg;
        end
    end

    assign out_pt = (cmd.out_sel == OUT_CUR) ? cur_reg : hd_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (cmd.out_load) begin
            m_data_reg.kept_x   <= out_pt[0];
            m_data_reg.kept_y   <= out_pt[1];
            m_data_reg.kept_z   <= out_pt[2];
            m_data_reg.run_last <= cmd.out_last;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_acc_follows_mul: assert property (@(posedge aclk) disable iff (!aresetn)
        acc_en_reg == $past(cmd.mul_go))
        else $error("accumulate stage out of step with the multiplier");

    a_clear_when_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.diff_load |-> !acc_en_reg)
        else $error("accumulators cleared with a product still in flight");

    a_valid_from_load: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(cmd.out_load))
        else $error("result valid raised without an output load");

endmodule

`default_nettype wire

FILE: rtl/polyline_angle_downsampler.sv
// top level: threshold register, controller and datapath of the polyline angle downsampler
//
// Thins a stream of 3D path points (Q15.16) by turn angle. Points come in on
// the s_ channel, one per transfer, path_end on the final point of a path.
// Kept points leave on the m_ channel; run_last marks the final point.
// cfg_data writes the Q1.15 cosine threshold; cfg_ready is always high.
// Write it only while the block is idle.
// Flow: the first point of a path and a second point that ends the path
// pass through the route and emit-current states to m_valid. Every later
// point runs 22 steps through the one shared multiplier plus route, drain
// and decide states, and the next input transfer is accepted only once the
// block is back in idle, so a point is through before the next one is taken.
// The middle point, if kept, goes out from the emit-held state after the
// decision, and on a path end the final point follows it from emit-current.
// Reset returns the threshold to cos(1.5 deg) and starts a new path.
// A stalled receiver holds the output register; when another result is due
// while one is still pending, s_ready stays low until the pending one is taken.
`default_nettype none

module polyline_angle_downsampler
    import pad_pkg::*;
(
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_valid,
    output logic                 s_ready,
    input  wire pad_in_t         s_data,
    output logic                 m_valid,
    input  wire logic            m_ready,
    output pad_out_t             m_data,
    input  wire logic            cfg_valid,
    output logic                 cfg_ready,
    input  wire logic [TH_W-1:0] cfg_data
);

    logic signed [TH_W-1:0] cos_th_reg;
    pad_cmd_t               cmd;
    pad_stat_t              stat;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cos_th_reg <= COS_TH_RESET;
        end else if (cfg_valid && cfg_ready) begin
            cos_th_reg <= cfg_data;
        end
    end

    pad_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    pad_dpath u_dpath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_data        (s_data),
        .cos_threshold (cos_th_reg),
        .cmd           (cmd),
        .stat          (stat),
        .m_ready       (m_ready),
        .m_valid       (m_valid),
        .m_data        (m_data)
    );

endmodule

`default_nettype wire
